### rtl/core/snep_pkg.sv
// Shared types, constants and the arctangent table for the scan normal estimator.
package snep_pkg;

	localparam int RADIUS_W = 23;
	localparam int WSAMP_W = 5;
	localparam int CORDIC_W = 44;
	localparam int ANG_W = 32;
	localparam int NORM_SHIFT = 40;
	localparam int COARSE_LIMIT = 32;
	localparam int COARSE_STEP = 8;
	localparam int UNIT_SHIFT = 24;
	localparam int TABLE_IDX_W = 5;

	localparam logic [1:0] REG_WINDOW_SAMPLES = 2'd0;
	localparam logic [1:0] REG_RADIUS_LIMIT = 2'd1;
	localparam logic [1:0] REG_SENSOR_X = 2'd2;
	localparam logic [1:0] REG_SENSOR_Y = 2'd3;

	localparam logic [ANG_W-1:0] QUARTER_TURN = 32'h4000_0000;
	localparam logic [ANG_W-1:0] THREE_QUARTER_TURN = 32'hC000_0000;

	typedef enum logic [4:0] {
		S_IDLE, S_CHECK, S_RD_C, S_LD_C, S_NR_RD, S_NR_SQ, S_NR_CMP, S_DECIDE,
		S_NB_RD, S_NB_LD, S_NB_MUL, S_NB_DOT, S_NB_VS, S_NB_VW, S_NB_RS, S_NB_RW,
		S_FIN_ST, S_FIN_W, S_EMIT, S_FINAL
	} seq_state_t;

	typedef enum logic [1:0] {
		CS_IDLE, CS_NORM, CS_ITER, CS_DONE
	} cordic_state_t;

	typedef struct packed {
		logic start;
		logic rotate;
	} cordic_ctrl_t;

	function automatic logic [ANG_W-1:0] atan_turn(input logic [TABLE_IDX_W-1:0] idx);
		logic [ANG_W-1:0] t;
		case (idx)
			5'd0: t = 32'd536870912;
			5'd1: t = 32'd316933406;
			5'd2: t = 32'd167458907;
			5'd3: t = 32'd85004756;
			5'd4: t = 32'd42667331;
			5'd5: t = 32'd21354465;
			5'd6: t = 32'd10679838;
			5'd7: t = 32'd5340245;
			5'd8: t = 32'd2670163;
			5'd9: t = 32'd1335087;
			5'd10: t = 32'd667544;
			5'd11: t = 32'd333772;
			5'd12: t = 32'd166886;
			5'd13: t = 32'd83443;
			5'd14: t = 32'd41722;
			5'd15: t = 32'd20861;
			5'd16: t = 32'd10430;
			5'd17: t = 32'd5215;
			5'd18: t = 32'd2608;
			5'd19: t = 32'd1304;
			5'd20: t = 32'd652;
			5'd21: t = 32'd326;
			5'd22: t = 32'd163;
			5'd23: t = 32'd81;
			default: t = '0;
		endcase
		return t;
	endfunction

endpackage

### rtl/core/snep_cell.sv
// One point cell of the window chain, passing its point to the next cell on a shift.
module snep_cell #(
	parameter int CW = 24
) (
	input  logic                 clk,
	input  logic                 shift,
	input  logic signed [CW-1:0] in_x,
	input  logic signed [CW-1:0] in_y,
	output logic signed [CW-1:0] x,
	output logic signed [CW-1:0] y
);
	always_ff @(posedge clk) begin
		if (shift) begin
			x <= in_x;
			y <= in_y;
		end
	end
endmodule

### rtl/core/snep_window.sv
// Chain of point cells, newest point in cell zero, with one registered read port.
module snep_window #(
	parameter int DEPTH = 17,
	parameter int CW = 24,
	parameter int IDX_W = 5
) (
	input  logic                 clk,
	input  logic                 shift,
	input  logic signed [CW-1:0] new_x,
	input  logic signed [CW-1:0] new_y,
	input  logic [IDX_W-1:0]     rd_idx,
	output logic signed [CW-1:0] rd_x,
	output logic signed [CW-1:0] rd_y
);
	logic signed [CW-1:0] xs [DEPTH];
	logic signed [CW-1:0] ys [DEPTH];

	snep_cell #(.CW(CW)) u_head (
		.clk(clk), .shift(shift), .in_x(new_x), .in_y(new_y), .x(xs[0]), .y(ys[0])
	);

	for (genvar k = 1; k < DEPTH; k++) begin : g_cell
		snep_cell #(.CW(CW)) u_cell (
			.clk(clk), .shift(shift), .in_x(xs[k-1]), .in_y(ys[k-1]),
			.x(xs[k]), .y(ys[k])
		);
	end

	always_ff @(posedge clk) begin
		rd_x <= xs[rd_idx];
		rd_y <= ys[rd_idx];
	end
endmodule

### rtl/core/snep_cordic.sv
// Shared iterative CORDIC unit for vectoring (atan2) and rotation (unit vector).
module snep_cordic #(
	parameter int STEPS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  snep_pkg::cordic_ctrl_t              ctrl,
	input  logic signed [snep_pkg::CORDIC_W-1:0] in_x,
	input  logic signed [snep_pkg::CORDIC_W-1:0] in_y,
	input  logic [snep_pkg::ANG_W-1:0]          in_ang,
	output logic                                done,
	output logic signed [snep_pkg::CORDIC_W-1:0] out_x,
	output logic signed [snep_pkg::CORDIC_W-1:0] out_y,
	output logic [snep_pkg::ANG_W-1:0]          out_ang
);
	import snep_pkg::*;

	localparam int STEP_W = $clog2(STEPS);
	localparam logic [CORDIC_W-1:0] NORM_LEVEL = CORDIC_W'(1) << NORM_SHIFT;
	localparam logic [CORDIC_W-1:0] COARSE_LEVEL = CORDIC_W'(1) << COARSE_LIMIT;
	localparam logic signed [CORDIC_W-1:0] UNIT = CORDIC_W'(1) << UNIT_SHIFT;

	cordic_state_t state_q, state_d;
	logic signed [CORDIC_W-1:0] x_q, y_q, dx, dy;
	logic [CORDIC_W-1:0] ax, ay;
	logic [ANG_W-1:0] acc_q, turn;
	logic signed [ANG_W:0] w_q;
	logic [STEP_W-1:0] i_q;
	logic rot_q, is_zero, coarse, fine;

	always_comb begin
		ax = x_q[CORDIC_W-1] ? $unsigned(-x_q) : $unsigned(x_q);
		ay = y_q[CORDIC_W-1] ? $unsigned(-y_q) : $unsigned(y_q);
		is_zero = (x_q == '0) && (y_q == '0);
		coarse = (ax < COARSE_LEVEL) && (ay < COARSE_LEVEL);
		fine = (ax < NORM_LEVEL) && (ay < NORM_LEVEL);
		dx = y_q >>> i_q;
		dy = x_q >>> i_q;
		turn = atan_turn(TABLE_IDX_W'(i_q));
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			CS_IDLE: begin
				if (ctrl.start) begin
					state_d = ctrl.rotate ? CS_ITER : CS_NORM;
				end
			end
			CS_NORM: begin
				if (is_zero) begin
					state_d = CS_DONE;
				end else if (!fine) begin
					state_d = CS_ITER;
				end
			end
			CS_ITER: begin
				if (i_q == STEP_W'(STEPS - 1)) begin
					state_d = CS_DONE;
				end
			end
			CS_DONE: state_d = CS_IDLE;
			default: state_d = CS_IDLE;
		endcase
	end

	always_comb begin
		done = (state_q == CS_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			CS_IDLE: begin
				if (ctrl.start) begin
					rot_q <= ctrl.rotate;
					i_q <= '0;
					acc_q <= '0;
					w_q <= $signed({3'b000, in_ang[ANG_W-3:0]});
					if (ctrl.rotate) begin
						case (in_ang[ANG_W-1:ANG_W-2])
							2'd0: begin x_q <= UNIT; y_q <= '0; end
							2'd1: begin x_q <= '0; y_q <= UNIT; end
							2'd2: begin x_q <= -UNIT; y_q <= '0; end
							default: begin x_q <= '0; y_q <= -UNIT; end
						endcase
					end else begin
						x_q <= in_x;
						y_q <= in_y;
					end
				end
			end
			CS_NORM: begin
				if (is_zero) begin
					acc_q <= '0;
				end else if (coarse) begin
					x_q <= x_q <<< COARSE_STEP;
					y_q <= y_q <<< COARSE_STEP;
				end else if (fine) begin
					x_q <= x_q <<< 1;
					y_q <= y_q <<< 1;
				end else if (x_q < 0) begin
					if (y_q >= 0) begin
						x_q <= y_q;
						y_q <= -x_q;
						acc_q <= QUARTER_TURN;
					end else begin
						x_q <= -y_q;
						y_q <= x_q;
						acc_q <= THREE_QUARTER_TURN;
					end
				end
			end
			CS_ITER: begin
				i_q <= i_q + 1'b1;
				if (!rot_q) begin
					if (y_q >= 0) begin
						x_q <= x_q + dx;
						y_q <= y_q - dy;
						acc_q <= acc_q + turn;
					end else begin
						x_q <= x_q - dx;
						y_q <= y_q + dy;
						acc_q <= acc_q - turn;
					end
				end else begin
					if (w_q >= 0) begin
						x_q <= x_q - dx;
						y_q <= y_q + dy;
						w_q <= w_q - $signed({1'b0, turn});
					end else begin
						x_q <= x_q + dx;
						y_q <= y_q - dy;
						w_q <= w_q + $signed({1'b0, turn});
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign out_x = x_q;
	assign out_y = y_q;
	assign out_ang = acc_q;
endmodule

### rtl/core/scan_normal_estimator_2d.sv
// Top level of the 2D scan normal estimator: sequencer, configuration and output register.
//
// Channel   Dir  Payload                                 Marker
// s_        in   tdata: point_x, point_y                 tlast: scan_last
// m_        out  tdata: normal_angle                     tlast: scan_end
// cfg_      in   addr: register index, wdata: value      we: write strobe
//
// One point is processed at a time; a point that releases no result goes through S_FINAL.
// Each result examines window entries one by one, then for every neighbor makes two passes
// of the shared CORDIC unit (CORDIC_STEPS iterations each, plus scaling in the first), and
// a last pass gives the angle. A last point can flush up to nine results. A result waits in
// S_EMIT while m_tready stalls.
// Reset empties the window; the output register holds a result until it is taken.
module scan_normal_estimator_2d #(
	parameter int MAX_SAMPLES = 16,
	parameter int COORD_WIDTH = 24,
	parameter int ANGLE_WIDTH = 16,
	parameter int CORDIC_STEPS = 16,
	localparam int IN_W = ((2 * COORD_WIDTH + 7) / 8) * 8,
	localparam int OUT_W = ((ANGLE_WIDTH + 7) / 8) * 8,
	localparam int CFG_W = (COORD_WIDTH > 23) ? COORD_WIDTH : 23
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // point_x, point_y
	input  logic             s_tlast,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,   // normal_angle
	output logic             m_tlast,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_addr,
	input  logic [CFG_W-1:0] cfg_wdata
);
	import snep_pkg::*;

	localparam int BACK_MAX = MAX_SAMPLES / 2;
	localparam int FWD_MAX = (MAX_SAMPLES + 1) / 2;
	localparam int WIN_DEPTH = BACK_MAX + FWD_MAX + 1;
	localparam int CNT_W = $clog2(WIN_DEPTH + 1);
	localparam int IDX_W = $clog2(WIN_DEPTH);
	localparam int N_W = $clog2(MAX_SAMPLES + 1);
	localparam int DIFF_W = COORD_WIDTH + 1;
	localparam int MAG_W = (DIFF_W > RADIUS_W) ? DIFF_W : RADIUS_W;
	localparam int SQ_W = 2 * RADIUS_W;
	localparam int PROD_W = 2 * DIFF_W;

	seq_state_t state_q, state_d;

	logic [WSAMP_W-1:0] wsamp_q;
	logic [RADIUS_W-1:0] radius_q;
	logic [SQ_W-1:0] rr_q;
	logic signed [COORD_WIDTH-1:0] sens_x_q, sens_y_q;

	logic [CNT_W-1:0] held_q, ev_q, b_q, e_q, s_q;
	logic last_q, dir_q;
	logic [N_W-1:0] n_eff;
	logic [N_W:0] n_plus;
	logic [CNT_W-1:0] back_c, fwd_c;
	logic [CNT_W:0] fwd1_c;
	logic back_ok, fwd_ok, emit_more, in_acc, slot_free, near;

	logic [CNT_W-1:0] rd_j;
	logic [IDX_W-1:0] rd_idx;
	logic signed [COORD_WIDTH-1:0] rd_x, rd_y, cx_q, cy_q;
	logic signed [DIFF_W-1:0] ox_q, oy_q, nx_q, ny_q, dxn, dyn;
	logic [MAG_W-1:0] adx, ady;
	logic far_q;
	logic [SQ_W-1:0] sqx_q, sqy_q;
	logic signed [PROD_W-1:0] p1_q, p2_q;
	logic signed [PROD_W:0] dot;

	cordic_ctrl_t cctrl;
	logic cdone;
	logic signed [CORDIC_W-1:0] op_x_q, op_y_q, c_x, c_y, sum_x_q, sum_y_q;
	logic [ANG_W-1:0] c_ang, rnd;

	logic out_valid_q, out_end_q;
	logic [ANGLE_WIDTH-1:0] out_angle_q;

	snep_window #(.DEPTH(WIN_DEPTH), .CW(COORD_WIDTH), .IDX_W(IDX_W)) u_window (
		.clk(clk), .shift(in_acc),
		.new_x(s_tdata[COORD_WIDTH-1:0]), .new_y(s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
		.rd_idx(rd_idx), .rd_x(rd_x), .rd_y(rd_y)
	);

	snep_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .ctrl(cctrl), .in_x(op_x_q), .in_y(op_y_q),
		.in_ang(c_ang), .done(cdone), .out_x(c_x), .out_y(c_y), .out_ang(c_ang)
	);

	always_comb begin
		n_eff = (int'(wsamp_q) > MAX_SAMPLES) ? N_W'(MAX_SAMPLES) : N_W'(wsamp_q);
		n_plus = {1'b0, n_eff} + 1'b1;
		back_c = CNT_W'(n_eff >> 1);
		fwd_c = CNT_W'(n_plus >> 1);
		fwd1_c = {1'b0, fwd_c} + 1'b1;
		back_ok = (b_q != '0) && ((ev_q - b_q) < back_c);
		fwd_ok = (e_q < held_q) && ({1'b0, e_q - ev_q} < fwd1_c);
		emit_more = ((held_q - ev_q) > fwd_c) || (last_q && (held_q > ev_q));
		in_acc = s_tvalid && s_tready;
		slot_free = !out_valid_q || m_tready;
		near = !far_q && ((SQ_W + 1)'(sqx_q) + (SQ_W + 1)'(sqy_q) < (SQ_W + 1)'(rr_q));
		dxn = DIFF_W'(rd_x) - DIFF_W'(cx_q);
		dyn = DIFF_W'(rd_y) - DIFF_W'(cy_q);
		adx = MAG_W'(dxn[DIFF_W-1] ? $unsigned(-dxn) : $unsigned(dxn));
		ady = MAG_W'(dyn[DIFF_W-1] ? $unsigned(-dyn) : $unsigned(dyn));
		dot = (PROD_W + 1)'(p1_q) + (PROD_W + 1)'(p2_q);
		rnd = c_ang + (ANG_W'(1) << (ANG_W - 1 - ANGLE_WIDTH));
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (in_acc) state_d = S_CHECK;
			S_CHECK: state_d = emit_more ? S_RD_C : S_FINAL;
			S_RD_C: state_d = S_LD_C;
			S_LD_C: state_d = S_NR_RD;
			S_NR_RD: begin
				if ((!dir_q && back_ok) || (dir_q && fwd_ok)) begin
					state_d = S_NR_SQ;
				end else if (dir_q) begin
					state_d = S_DECIDE;
				end
			end
			S_NR_SQ: state_d = S_NR_CMP;
			S_NR_CMP: state_d = (!near && dir_q) ? S_DECIDE : S_NR_RD;
			S_DECIDE: state_d = ((e_q - b_q) < CNT_W'(2)) ? S_FIN_ST : S_NB_RD;
			S_NB_RD: begin
				if (s_q == e_q) begin
					state_d = S_FIN_ST;
				end else if (s_q != ev_q) begin
					state_d = S_NB_LD;
				end
			end
			S_NB_LD: state_d = S_NB_MUL;
			S_NB_MUL: state_d = ((nx_q == '0) && (ny_q == '0)) ? S_NB_RD : S_NB_DOT;
			S_NB_DOT: state_d = S_NB_VS;
			S_NB_VS: state_d = S_NB_VW;
			S_NB_VW: if (cdone) state_d = S_NB_RS;
			S_NB_RS: state_d = S_NB_RW;
			S_NB_RW: if (cdone) state_d = S_NB_RD;
			S_FIN_ST: state_d = S_FIN_W;
			S_FIN_W: if (cdone) state_d = S_EMIT;
			S_EMIT: if (slot_free) state_d = S_CHECK;
			S_FINAL: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		s_tready = (state_q == S_IDLE);
		cctrl.start = (state_q == S_NB_VS) || (state_q == S_NB_RS) || (state_q == S_FIN_ST);
		cctrl.rotate = (state_q == S_NB_RS);
		case (state_q)
			S_RD_C: rd_j = ev_q;
			S_NR_RD: rd_j = dir_q ? e_q : (b_q - 1'b1);
			S_NB_RD: rd_j = s_q;
			default: rd_j = ev_q;
		endcase
		rd_idx = IDX_W'(held_q - 1'b1 - rd_j);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wsamp_q <= WSAMP_W'(4);
			radius_q <= RADIUS_W'(31);
			sens_x_q <= '0;
			sens_y_q <= '0;
			held_q <= '0;
			ev_q <= '0;
			last_q <= 1'b0;
			dir_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_addr)
					REG_WINDOW_SAMPLES: wsamp_q <= cfg_wdata[WSAMP_W-1:0];
					REG_RADIUS_LIMIT: radius_q <= cfg_wdata[RADIUS_W-1:0];
					REG_SENSOR_X: sens_x_q <= $signed(cfg_wdata[COORD_WIDTH-1:0]);
					REG_SENSOR_Y: sens_y_q <= $signed(cfg_wdata[COORD_WIDTH-1:0]);
					default: begin
					end
				endcase
			end
			if (in_acc) begin
				held_q <= held_q + 1'b1;
				last_q <= s_tlast;
			end
			if (state_q == S_LD_C) begin
				dir_q <= 1'b0;
			end else if (state_q == S_NR_RD && !dir_q && !back_ok) begin
				dir_q <= 1'b1;
			end else if (state_q == S_NR_CMP && !near) begin
				dir_q <= 1'b1;
			end
			if (state_q == S_EMIT && slot_free) begin
				out_valid_q <= 1'b1;
				ev_q <= ev_q + 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == S_FINAL) begin
				if (last_q) begin
					held_q <= '0;
					ev_q <= '0;
				end else if (ev_q > back_c) begin
					held_q <= held_q - (ev_q - back_c);
					ev_q <= back_c;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		rr_q <= SQ_W'(radius_q) * SQ_W'(radius_q);
		case (state_q)
			S_LD_C: begin
				cx_q <= rd_x;
				cy_q <= rd_y;
				ox_q <= DIFF_W'(sens_x_q) - DIFF_W'(rd_x);
				oy_q <= DIFF_W'(sens_y_q) - DIFF_W'(rd_y);
				b_q <= ev_q;
				e_q <= ev_q;
			end
			S_NR_SQ: begin
				far_q <= (adx >= MAG_W'(radius_q)) || (ady >= MAG_W'(radius_q));
				sqx_q <= SQ_W'(adx[RADIUS_W-1:0]) * SQ_W'(adx[RADIUS_W-1:0]);
				sqy_q <= SQ_W'(ady[RADIUS_W-1:0]) * SQ_W'(ady[RADIUS_W-1:0]);
			end
			S_NR_CMP: begin
				if (near) begin
					if (dir_q) begin
						e_q <= e_q + 1'b1;
					end else begin
						b_q <= b_q - 1'b1;
					end
				end
			end
			S_DECIDE: begin
				s_q <= b_q;
				sum_x_q <= '0;
				sum_y_q <= '0;
				op_x_q <= CORDIC_W'(ox_q);
				op_y_q <= CORDIC_W'(oy_q);
			end
			S_NB_RD: begin
				if (s_q == e_q) begin
					op_x_q <= sum_x_q;
					op_y_q <= sum_y_q;
				end else begin
					s_q <= s_q + 1'b1;
				end
			end
			S_NB_LD: begin
				nx_q <= DIFF_W'(rd_y) - DIFF_W'(cy_q);
				ny_q <= DIFF_W'(cx_q) - DIFF_W'(rd_x);
			end
			S_NB_MUL: begin
				p1_q <= PROD_W'(nx_q) * PROD_W'(ox_q);
				p2_q <= PROD_W'(ny_q) * PROD_W'(oy_q);
			end
			S_NB_DOT: begin
				if (dot < 0) begin
					op_x_q <= -CORDIC_W'(nx_q);
					op_y_q <= -CORDIC_W'(ny_q);
				end else begin
					op_x_q <= CORDIC_W'(nx_q);
					op_y_q <= CORDIC_W'(ny_q);
				end
			end
			S_NB_RW: begin
				if (cdone) begin
					sum_x_q <= sum_x_q + c_x;
					sum_y_q <= sum_y_q + c_y;
				end
			end
			default: begin
			end
		endcase
		if (state_q == S_EMIT && slot_free) begin
			out_angle_q <= rnd[ANG_W-1 -: ANGLE_WIDTH];
			out_end_q <= last_q && ({1'b0, ev_q} + 1'b1 == {1'b0, held_q});
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = OUT_W'(out_angle_q);
	assign m_tlast = out_end_q;

	a_ev_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		ev_q <= held_q)
		else $error("emitted count exceeds held points");

	a_window_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (held_q < CNT_W'(WIN_DEPTH)))
		else $error("window full while waiting for a point");

	a_cordic_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		cdone |-> ((state_q == S_NB_VW) || (state_q == S_NB_RW) || (state_q == S_FIN_W)))
		else $error("CORDIC finished outside a wait state");

	a_emit_loads_output: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_EMIT) && slot_free) |=> m_tvalid)
		else $error("result not presented after emit");
endmodule

### sim/testbench.sv
// Testbench for scan_normal_estimator_2d: directed table, random scans, self-checking predictor.
`timescale 1ns / 1ps

module testbench;
	import snep_pkg::*;

	localparam int WATCHDOG_LIMIT = 40000;
	localparam int SETTLE_CYCLES = 80;
	localparam int WIN_SLOTS = 17;

	typedef struct {
		logic signed [23:0] x;
		logic signed [23:0] y;
		bit last;
		bit chk;
		logic [15:0] angle;
	} row_t;

	typedef struct {
		logic [15:0] angle;
		bit scan_end;
	} normal_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [47:0] s_tdata = '0;  // point_x, point_y
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [15:0] m_tdata;  // normal_angle
	logic m_tlast;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_addr = REG_WINDOW_SAMPLES;
	logic [23:0] cfg_wdata = '0;

	scan_normal_estimator_2d u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	const bit [31:0] arc_step[16] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861};

	longint pt_x[WIN_SLOTS];
	longint pt_y[WIN_SLOTS];
	int unsigned held_cnt = 0;
	int unsigned emitted_cnt = 0;
	int unsigned win_n = 4;
	longint radius = 31;
	longint sensor_x = 0;
	longint sensor_y = 0;

	normal_t normals_due[$];
	int fails = 0;
	int points_sent = 0;
	int normals_seen = 0;
	int scans_sent = 0;
	int idle_cycles = 0;
	bit no_gaps = 1'b0;

	function automatic longint absl(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic bit [31:0] vec_angle(longint y, longint x);
		bit [31:0] acc;
		longint t, dx, dy;
		acc = 0;
		if (x == 0 && y == 0)
			return 0;
		while (absl(x) < (64'sd1 <<< 40) && absl(y) < (64'sd1 <<< 40)) begin
			x = x * 2;
			y = y * 2;
		end
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; acc = 32'h4000_0000;
			end else begin
				t = x; x = -y; y = t; acc = 32'hC000_0000;
			end
		end
		for (int i = 0; i < 16; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; acc += arc_step[i];
			end else begin
				x -= dx; y += dy; acc -= arc_step[i];
			end
		end
		return acc;
	endfunction

	function automatic void unit_vec(bit [31:0] ang, output longint ux, output longint uy);
		longint x, y, w, dx, dy;
		x = 0;
		y = 0;
		w = longint'(ang[29:0]);
		case (ang[31:30])
			2'd0: x = 64'sd1 <<< 24;
			2'd1: y = 64'sd1 <<< 24;
			2'd2: x = -(64'sd1 <<< 24);
			default: y = -(64'sd1 <<< 24);
		endcase
		for (int i = 0; i < 16; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (w >= 0) begin
				x -= dx; y += dy; w -= longint'(arc_step[i]);
			end else begin
				x += dx; y -= dy; w += longint'(arc_step[i]);
			end
		end
		ux = x;
		uy = y;
	endfunction

	function automatic bit within_radius(int unsigned a, int unsigned c);
		longint dx, dy;
		dx = pt_x[a] - pt_x[c];
		dy = pt_y[a] - pt_y[c];
		if (absl(dx) >= radius || absl(dy) >= radius)
			return 0;
		return dx * dx + dy * dy < radius * radius;
	endfunction

	function automatic bit [31:0] normal_at(int unsigned c, int unsigned back, int unsigned fwd);
		int unsigned b, e;
		longint ox, oy, sx, sy, nx, ny, ux, uy;
		b = c;
		e = c;
		ox = sensor_x - pt_x[c];
		oy = sensor_y - pt_y[c];
		sx = 0;
		sy = 0;
		while (b > 0 && c - b < back && within_radius(b - 1, c))
			b--;
		while (e < held_cnt && e - c < fwd + 1 && within_radius(e, c))
			e++;
		if (e - b < 2)
			return vec_angle(oy, ox);
		for (int unsigned s = b; s < e; s++) begin
			if (s == c)
				continue;
			nx = -(pt_y[c] - pt_y[s]);
			ny = pt_x[c] - pt_x[s];
			if (nx == 0 && ny == 0)
				continue;
			if (nx * ox + ny * oy < 0) begin
				nx = -nx;
				ny = -ny;
			end
			unit_vec(vec_angle(ny, nx), ux, uy);
			sx += ux;
			sy += uy;
		end
		return vec_angle(sy, sx);
	endfunction

	function automatic void predict_point(logic signed [23:0] x, logic signed [23:0] y, bit last);
		int unsigned n, back, fwd, c, drop;
		bit [31:0] r;
		n = win_n > 16 ? 16 : win_n;
		back = n / 2;
		fwd = (n + 1) / 2;
		if (held_cnt >= WIN_SLOTS) begin
			for (int i = 0; i < WIN_SLOTS - 1; i++) begin
				pt_x[i] = pt_x[i + 1];
				pt_y[i] = pt_y[i + 1];
			end
			held_cnt = WIN_SLOTS - 1;
			if (emitted_cnt > 0)
				emitted_cnt--;
		end
		pt_x[held_cnt] = longint'(x);
		pt_y[held_cnt] = longint'(y);
		held_cnt++;
		while (held_cnt - emitted_cnt > fwd || (last && held_cnt > emitted_cnt)) begin
			c = emitted_cnt;
			r = normal_at(c, back, fwd) + 32'h8000;
			normals_due.insert(normals_due.size(),
				'{angle: r[31:16], scan_end: last && c + 1 == held_cnt});
			emitted_cnt++;
		end
		if (last) begin
			held_cnt = 0;
			emitted_cnt = 0;
		end else if (emitted_cnt > back) begin
			drop = emitted_cnt - back;
			for (int unsigned i = 0; i < held_cnt - drop; i++) begin
				pt_x[i] = pt_x[i + drop];
				pt_y[i] = pt_y[i + drop];
			end
			held_cnt -= drop;
			emitted_cnt = back;
		end
	endfunction

	task automatic report(string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		fails++;
	endtask

	always @(posedge clk) begin : monitor
		normal_t e;
		if (m_tvalid && m_tready) begin
			normals_seen++;
			if (normals_due.size() == 0) begin
				report($sformatf("unexpected normal %h", m_tdata));
			end else begin
				e = normals_due.pop_front();
				if (m_tdata !== e.angle)
					report($sformatf("normal_angle %h, want %h", m_tdata, e.angle));
				if (m_tlast !== e.scan_end)
					report($sformatf("scan_end %b, want %b", m_tlast, e.scan_end));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
				if (idle_cycles == WATCHDOG_LIMIT) begin
					$display("Watchdog expired, %0d normals outstanding", normals_due.size());
					$display("TEST FAILED");
					$finish;
				end
			end
		end
	end

	initial begin : sink
		int stall;
		forever begin
			stall = no_gaps ? 0 : $urandom_range(0, 15);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	task automatic send_point(logic signed [23:0] x, logic signed [23:0] y, bit last);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {y, x};
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		predict_point(x, y, last);
		points_sent++;
		if (last)
			scans_sent++;
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		while (normals_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_config(int unsigned n, longint r, longint sx, longint sy);
		logic [23:0] vals[4];
		vals = '{24'(n), 24'(r), 24'(sx), 24'(sy)};
		drain();
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_addr <= 2'(i);
			cfg_wdata <= vals[i];
			@(posedge clk);
			case (2'(i))
				REG_WINDOW_SAMPLES: win_n = vals[i][4:0];
				REG_RADIUS_LIMIT: radius = longint'(vals[i][22:0]);
				REG_SENSOR_X: sensor_x = longint'(signed'(vals[i]));
				REG_SENSOR_Y: sensor_y = longint'(signed'(vals[i]));
				default: begin
				end
			endcase
		end
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		row_t rows[$];
		int unsigned p_n[8] = '{16, 1, 0, 31, 7, 2, 9, 5};
		int unsigned p_r[8] = '{2000, 500, 100, 8388607, 0, 300, 60, 1};
		int unsigned p_step[8] = '{1200, 400, 80, 3000000, 50, 250, 40, 2};
		int remaining, len, step;
		logic signed [23:0] bx, by;
		bit last;

		rows = '{
			'{24'sd0, 24'sd0, 1, 1, 16'h0000},
			'{24'sd8388607, 24'sh800000, 1, 0, 16'h0},
			'{24'sh800000, 24'sd8388607, 1, 0, 16'h0},
			'{24'sd1024, 24'sd0, 1, 0, 16'h0},
			'{24'sd100, 24'sd100, 0, 0, 16'h0},
			'{24'sd110, 24'sd105, 0, 0, 16'h0},
			'{24'sd120, 24'sd100, 0, 0, 16'h0},
			'{24'sd130, 24'sd110, 0, 0, 16'h0},
			'{24'sd138, 24'sd95, 0, 0, 16'h0},
			'{24'sd145, 24'sd99, 1, 0, 16'h0},
			'{24'sd200, 24'sd200, 0, 0, 16'h0},
			'{24'sd200, 24'sd200, 0, 0, 16'h0},
			'{24'sd200, 24'sd200, 1, 0, 16'h0},
			'{24'sd100, 24'sd0, 0, 0, 16'h0},
			'{24'sd110, 24'sd0, 0, 0, 16'h0},
			'{24'sd120, 24'sd0, 1, 0, 16'h0},
			'{-24'sd500, -24'sd500, 0, 0, 16'h0},
			'{-24'sd480, -24'sd510, 0, 0, 16'h0},
			'{24'sd4000, 24'sd4000, 0, 0, 16'h0},
			'{-24'sd470, -24'sd520, 1, 0, 16'h0}};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			send_point(rows[i].x, rows[i].y, rows[i].last);
			if (rows[i].chk)
				normals_due[$].angle = rows[i].angle;
		end

		for (int p = 0; p < 8; p++) begin
			write_config(p_n[p], p_r[p],
				p == 3 ? -64'sd8388608 : longint'(signed'(24'($urandom))) >>> $urandom_range(0, 20),
				p == 3 ? 64'sd8388607 : longint'(signed'(24'($urandom))) >>> $urandom_range(0, 20));
			no_gaps = (p % 3 == 1);
			remaining = 42;
			while (remaining > 0) begin
				if (p == 5 && remaining == 21)
					drain();
				if ($urandom_range(0, 99) < 12) begin
					send_point(24'($urandom), 24'($urandom), $urandom_range(0, 7) == 0);
					remaining--;
				end else begin
					len = $urandom_range(1, 20);
					bx = 24'($urandom) >>> $urandom_range(1, 12);
					by = 24'($urandom) >>> $urandom_range(1, 12);
					for (int k = 0; k < len && remaining > 0; k++) begin
						step = p_step[p];
						bx = bx + 24'($urandom_range(0, 2 * step)) - 24'(step);
						by = by + 24'($urandom_range(0, 2 * step)) - 24'(step);
						last = (k == len - 1) || (remaining == 1 && p != 2);
						send_point(bx, by, last);
						remaining--;
					end
				end
			end
		end
		send_point(24'sd0, 24'sd0, 1);
		drain();

		$display("Sent %0d points in %0d scans, checked %0d normals across 9 settings.",
			points_sent, scans_sent, normals_seen);
		$display("Settings spanned window sizes 0 to 31, radii 0 to max and extreme sensors.");
		if (fails == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches", fails);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/core/snep_pkg.sv
rtl/core/snep_cell.sv
rtl/core/snep_window.sv
rtl/core/snep_cordic.sv
rtl/core/scan_normal_estimator_2d.sv
sim/testbench.sv
